/* sv/lzwvd_pkg.sv */
// Package for the LZW variable-width decoder: beat types, controller states,
// command and status bundles, fixed code constants. No dependencies.
package lzwvd_pkg;

   localparam int MAX_WIDTH    = 12;
   localparam int FIRST_WIDTH  = 8;
   localparam int NUM_LITERALS = 256;
   localparam int RESULT_CAP   = 32;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       string_end;
      logic       stream_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UNPACK,
      ST_LITERAL,
      ST_WALK_START,
      ST_WALK,
      ST_UNDEF,
      ST_ADD,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic unpack;
      logic literal;
      logic walk_start;
      logic walk;
      logic undef;
      logic add;
      logic emit_ld;
      logic emit_take;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic has_code;
      logic first_done;
      logic defined;
      logic walk_last;
      logic emit_last;
   } sts_type;

endpackage

/* sv/lzwvd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzwvd_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/lzwvd_ctrl.sv */
// Controller state machine of the LZW decoder: sequences unpack, chain walk,
// table update and byte emission. Depends on lzwvd_pkg.
module lzwvd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   input  lzwvd_pkg::sts_type sts,
   output lzwvd_pkg::cmd_type cmd
);
   import lzwvd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UNPACK;
            end
         end
         ST_UNPACK: begin
            cmd.unpack = 1'b1;
            if (!sts.has_code)        state_in = ST_FINISH;
            else if (!sts.first_done) state_in = ST_LITERAL;
            else if (sts.defined)     state_in = ST_WALK_START;
            else                      state_in = ST_UNDEF;
         end
         ST_LITERAL: begin
            cmd.literal = 1'b1;
            state_in    = ST_EMIT_RD;
         end
         ST_WALK_START: begin
            cmd.walk_start = 1'b1;
            state_in       = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_last) state_in = ST_ADD;
         end
         ST_UNDEF: begin
            cmd.undef = 1'b1;
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.emit_ld = 1'b1;
            state_in    = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               cmd.emit_take = 1'b1;
               state_in      = sts.emit_last ? ST_FINISH : ST_EMIT_RD;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

/* sv/lzwvd_datapath.sv */
// Datapath of the LZW decoder: bit buffer, code table RAM, string stack RAM
// and output register. Depends on lzwvd_pkg and lzwvd_ram.
module lzwvd_datapath #(
   parameter int DICT_ENTRIES = 4096,
   parameter int MAX_STRING   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  lzwvd_pkg::cmd_type cmd,
   output lzwvd_pkg::sts_type sts,
   input  lzwvd_pkg::req_type req_data,
   output logic               rsp_valid,
   output lzwvd_pkg::rsp_type rsp_data
);
   import lzwvd_pkg::*;

   localparam int DA_W   = $clog2(DICT_ENTRIES);
   localparam int STK_W  = $clog2(MAX_STRING);
   localparam int LEN_W  = $clog2(MAX_STRING + 1);
   localparam int DICT_W = 12 + 8 + LEN_W;

   logic [19:0]      bit_buf_ff, bit_buf_in;
   logic [4:0]       bits_ff, bits_in;
   logic [3:0]       width_ff, width_in;
   logic [12:0]      entry_cnt_ff, entry_cnt_in;
   logic [11:0]      prev_code_ff, prev_code_in;
   logic [LEN_W-1:0] prev_len_ff, prev_len_in;
   logic [7:0]       prev_first_ff, prev_first_in;
   logic             first_done_ff, first_done_in;
   logic             fin_ff;
   logic [11:0]      code_ff;
   logic             defined_ff;
   logic [11:0]      k_ff;
   logic [LEN_W-1:0] idx_ff;
   logic [LEN_W-1:0] n_ff;
   logic             walk_first_ff;
   logic [7:0]       cur0_ff;
   logic [STK_W-1:0] j_ff;
   logic [LEN_W-1:0] em_cnt_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic              dict_we;
   logic [DA_W-1:0]   dict_raddr;
   logic [DICT_W-1:0] dict_wdata, dict_rdata;
   logic              stk_we;
   logic [STK_W-1:0]  stk_waddr;
   logic [7:0]        stk_wdata, stk_rdata;

   // Width after growth: widen while the table has reached 2^width.
   function automatic logic [3:0] grow_width(input logic [3:0] w, input logic [12:0] cnt);
      logic [3:0] r;
      r = w;
      for (int s = 0; s < 4; s++) begin
         if (r < 4'(MAX_WIDTH) && cnt >= (13'd1 << r)) r = r + 4'd1;
      end
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
      logic [LEN_W-1:0] r;
      r = l;
      if (r == '0) r = LEN_W'(1);
      if (r > LEN_W'(MAX_STRING)) r = LEN_W'(MAX_STRING);
      return r;
   endfunction

   // unpack
   logic [3:0]  w_grow;
   logic [4:0]  sh;
   logic [19:0] shifted, code_mask, keep_mask;
   logic [11:0] code_x;
   assign w_grow    = first_done_ff ? grow_width(width_ff, entry_cnt_ff) : width_ff;
   assign sh        = bits_ff - {1'b0, w_grow};
   assign shifted   = bit_buf_ff >> sh;
   assign code_mask = (20'd1 << w_grow) - 20'd1;
   assign keep_mask = (20'd1 << sh) - 20'd1;
   assign code_x    = 12'(shifted & code_mask);

   // chain walk
   logic              k_lit;
   logic [LEN_W-1:0]  rd_len, n_walk, pos;
   logic [7:0]        rd_tail, tail;
   logic [11:0]       rd_prefix, next_k;
   assign rd_len    = dict_rdata[LEN_W-1:0];
   assign rd_tail   = dict_rdata[LEN_W+7:LEN_W];
   assign rd_prefix = dict_rdata[LEN_W+19:LEN_W+8];
   assign k_lit     = k_ff < 12'(NUM_LITERALS);
   assign tail      = k_lit ? k_ff[7:0] : rd_tail;
   assign n_walk    = walk_first_ff ? (k_lit ? LEN_W'(1) : clamp_len(rd_len)) : n_ff;
   assign pos       = walk_first_ff ? n_walk - LEN_W'(1) : idx_ff;
   assign next_k    = k_lit ? 12'd0 : rd_prefix;
   assign dict_raddr = cmd.walk_start ? code_ff[DA_W-1:0] : next_k[DA_W-1:0];

   logic can_add, em_last;
   logic [LEN_W-1:0] n_undef, n_final;
   assign can_add = (prev_len_ff < LEN_W'(MAX_STRING)) && (entry_cnt_ff < 13'(DICT_ENTRIES));
   assign n_undef = (prev_len_ff < LEN_W'(MAX_STRING)) ? prev_len_ff + LEN_W'(1) : prev_len_ff;
   assign n_final = n_ff;
   assign em_last = (LEN_W'(j_ff) + LEN_W'(1)) == em_cnt_ff;

   assign dict_we    = cmd.add && can_add;
   assign dict_wdata = {prev_code_ff, cur0_ff, prev_len_ff + LEN_W'(1)};

   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = pos[STK_W-1:0];
      stk_wdata = tail;
      if (cmd.walk) begin
         stk_we = 1'b1;
      end else if (cmd.literal) begin
         stk_we    = 1'b1;
         stk_waddr = '0;
         stk_wdata = code_ff[7:0];
      end else if (cmd.undef && prev_len_ff < LEN_W'(MAX_STRING)) begin
         stk_we    = 1'b1;
         stk_waddr = prev_len_ff[STK_W-1:0];
         stk_wdata = prev_first_ff;
      end
   end

   // decoder state, back to reset values after the final byte
   always_comb begin
      bit_buf_in    = bit_buf_ff;
      bits_in       = bits_ff;
      width_in      = width_ff;
      entry_cnt_in  = entry_cnt_ff;
      prev_code_in  = prev_code_ff;
      prev_len_in   = prev_len_ff;
      prev_first_in = prev_first_ff;
      first_done_in = first_done_ff;
      if (cmd.load) begin
         bit_buf_in = {bit_buf_ff[11:0], req_data.in_byte};
         bits_in    = bits_ff + 5'd8;
      end
      if (cmd.unpack) begin
         width_in = w_grow;
         if (bits_ff >= {1'b0, w_grow}) begin
            bits_in    = sh;
            bit_buf_in = bit_buf_ff & keep_mask;
         end
      end
      if (cmd.literal) begin
         prev_code_in  = {4'd0, code_ff[7:0]};
         prev_len_in   = LEN_W'(1);
         prev_first_in = code_ff[7:0];
         first_done_in = 1'b1;
         width_in      = 4'(FIRST_WIDTH + 1);
      end
      if (cmd.add) begin
         if (can_add) entry_cnt_in = entry_cnt_ff + 13'd1;
         if (defined_ff)   prev_code_in = code_ff;
         else if (can_add) prev_code_in = entry_cnt_ff[11:0];
         prev_len_in   = n_final;
         prev_first_in = cur0_ff;
      end
      if (cmd.finish && fin_ff) begin
         bit_buf_in    = '0;
         bits_in       = '0;
         width_in      = 4'(FIRST_WIDTH);
         entry_cnt_in  = 13'(NUM_LITERALS);
         prev_code_in  = '0;
         prev_len_in   = '0;
         prev_first_in = '0;
         first_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_buf_ff    <= '0;
         bits_ff       <= '0;
         width_ff      <= 4'(FIRST_WIDTH);
         entry_cnt_ff  <= 13'(NUM_LITERALS);
         prev_code_ff  <= '0;
         prev_len_ff   <= '0;
         prev_first_ff <= '0;
         first_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bit_buf_ff    <= bit_buf_in;
         bits_ff       <= bits_in;
         width_ff      <= width_in;
         entry_cnt_ff  <= entry_cnt_in;
         prev_code_ff  <= prev_code_in;
         prev_len_ff   <= prev_len_in;
         prev_first_ff <= prev_first_in;
         first_done_ff <= first_done_in;
         if (cmd.emit_ld)        rsp_valid_ff <= 1'b1;
         else if (cmd.emit_take) rsp_valid_ff <= 1'b0;
      end
   end

   // working registers of one step
   always_ff @(posedge clock) begin
      if (cmd.load) fin_ff <= req_data.final_byte;
      if (cmd.unpack) begin
         code_ff    <= code_x;
         defined_ff <= {1'b0, code_x} < entry_cnt_ff;
      end
      if (cmd.walk_start) begin
         k_ff          <= code_ff;
         walk_first_ff <= 1'b1;
      end
      if (cmd.walk) begin
         walk_first_ff <= 1'b0;
         n_ff          <= n_walk;
         k_ff          <= next_k;
         idx_ff        <= pos - LEN_W'(1);
         if (pos == '0) cur0_ff <= tail;
      end
      if (cmd.undef) begin
         n_ff    <= n_undef;
         cur0_ff <= prev_first_ff;
      end
      if (cmd.literal) begin
         j_ff      <= '0;
         em_cnt_ff <= LEN_W'(1);
      end
      if (cmd.add) begin
         j_ff      <= '0;
         em_cnt_ff <= (n_ff > LEN_W'(RESULT_CAP)) ? LEN_W'(RESULT_CAP) : n_ff;
      end
      if (cmd.emit_take && !em_last) j_ff <= j_ff + STK_W'(1);
      if (cmd.emit_ld) begin
         rsp_data_ff.out_byte   <= stk_rdata;
         rsp_data_ff.string_end <= em_last;
         rsp_data_ff.stream_end <= em_last && fin_ff;
      end
   end

   lzwvd_ram #(.WIDTH(DICT_W), .DEPTH(DICT_ENTRIES)) u_dict (
      .clock(clock), .we(dict_we), .waddr(entry_cnt_ff[DA_W-1:0]), .wdata(dict_wdata),
      .raddr(dict_raddr), .rdata(dict_rdata)
   );

   lzwvd_ram #(.WIDTH(8), .DEPTH(MAX_STRING)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(j_ff), .rdata(stk_rdata)
   );

   assign sts.has_code   = bits_ff >= {1'b0, w_grow};
   assign sts.first_done = first_done_ff;
   assign sts.defined    = {1'b0, code_x} < entry_cnt_ff;
   assign sts.walk_last  = pos == '0;
   assign sts.emit_last  = em_last;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;
endmodule

/* sv/lzw_variable_width_decoder.sv */
// LZW decoder with code widths from 9 to 12 bits. Each req beat carries one
// compressed byte (MSB first) and a final-byte flag; at most one code is
// completed per byte. The first code of a stream is an 8-bit literal. A
// defined code unwinds its prefix chain through the code table RAM, one entry
// per cycle, into a string stack RAM; an undefined code reuses the previous
// string plus its first byte. Each decoded byte leaves as one rsp beat, with
// string_end on the last byte of a code and stream_end on the last byte
// caused by the final byte. One byte is worked on at a time, and req_ready
// stays low until it is done. The controller steps through, per byte: accept,
// unpack, finish when it completes no code; accept, unpack, literal step,
// one emitted beat, finish for the first literal; accept, unpack,
// undefined-code step, table update, the emitted beats, finish for an
// undefined code; accept, unpack, walk start, one walk step per string byte,
// table update, the emitted beats, finish for a defined code. Each emitted
// beat is a stack RAM read, an output load and a wait for rsp_ready, so a
// low rsp_ready holds the byte. After the final byte, leftover bits are
// dropped and the decoder returns to its reset state; no table clearing
// pass is needed, since table entries are only read below the entry count.
module lzw_variable_width_decoder #(
   parameter int DICT_ENTRIES = 4096,
   parameter int MAX_STRING   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lzwvd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lzwvd_pkg::rsp_type rsp_data
);
   import lzwvd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller: sequence one byte at a time
   lzwvd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   // datapath: hold bit buffer, table, stack and output beat
   lzwvd_datapath #(.DICT_ENTRIES(DICT_ENTRIES), .MAX_STRING(MAX_STRING)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // no new byte while a decoded beat is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("req_ready high while rsp beat pending");

   // a taken byte blocks the input for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input reopened right after accept");

   // stream end only ever marks the last byte of a code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stream_end) |-> rsp_data.string_end)
      else $error("stream_end without string_end");
endmodule
